>>> sv/quaternion_arithmetic_unit_assert.svh
// assertion macros for the quaternion arithmetic unit
`ifndef QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define QAU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define QAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/qau_pkg.sv
// shared constants, types and helper functions of the quaternion arithmetic unit
package qau_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 28;
	localparam int CMD_W     = 4;
	localparam int STATUS_W  = 2;

	// full product of two sign-extended words, and its rounded form
	localparam int PROD_W = 2 * (WORD_BITS + 1);
	localparam int RND_W  = PROD_W - FRAC_BITS;
	// magnitude of a word shifted up by the fraction bits
	localparam int NUM_W  = WORD_BITS + FRAC_BITS;
	// working accumulator, holds signed quotients
	localparam int ACC_W  = NUM_W + 1;
	// divisor magnitude, sized for the squared length of a quaternion
	localparam int DEN_W  = 2 * WORD_BITS - FRAC_BITS + 2;
	// square root radicand: squared length shifted up by the fraction bits
	localparam int RAD_W  = 2 * WORD_BITS + 2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// command codes on the input channel
	localparam logic [CMD_W-1:0] CMD_ADD   = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_SUB   = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_MUL   = CMD_W'(2);
	localparam logic [CMD_W-1:0] CMD_SCALE = CMD_W'(3);
	localparam logic [CMD_W-1:0] CMD_DIVS  = CMD_W'(4);
	localparam logic [CMD_W-1:0] CMD_CONJ  = CMD_W'(5);
	localparam logic [CMD_W-1:0] CMD_NEG   = CMD_W'(6);
	localparam logic [CMD_W-1:0] CMD_DOT   = CMD_W'(7);
	localparam logic [CMD_W-1:0] CMD_SQLEN = CMD_W'(8);
	localparam logic [CMD_W-1:0] CMD_LEN   = CMD_W'(9);
	localparam logic [CMD_W-1:0] CMD_NORM  = CMD_W'(10);
	localparam logic [CMD_W-1:0] CMD_INV   = CMD_W'(11);
	localparam logic [CMD_W-1:0] CMD_QUOT  = CMD_W'(12);
	localparam logic [CMD_W-1:0] CMD_LERP  = CMD_W'(13);

	// status codes on the output channel
	localparam logic [STATUS_W-1:0] ST_OK  = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_DZ  = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_SAT = STATUS_W'(2);

	typedef logic [WORD_BITS-1:0]      word_t;
	typedef logic [3:0][WORD_BITS-1:0] quat_t;

	// operation class decided by the front end
	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_SCALE, OP_DIVS, OP_CONJ, OP_NEG, OP_DOT,
		OP_SQLEN, OP_LEN, OP_NORM, OP_INV, OP_QUOT, OP_LERP, OP_NONE
	} op_t;

	// one classified request as it sits in the queue
	typedef struct packed {
		op_t   op;
		logic  s_zero;
		quat_t a;
		quat_t b;
		word_t s;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		word_t w;
		logic  ovf;
	} sat_t;

	// one term of the Hamilton product: b index, a index, subtract
	typedef struct packed {
		logic [1:0] bi;
		logic [1:0] ai;
		logic       neg;
	} hp_t;

	// sign-extend a word by one bit
	function automatic logic signed [WORD_BITS:0] sx_word(word_t w);
		return $signed({w[WORD_BITS-1], w});
	endfunction

	// clip an accumulator value to the word range
	function automatic sat_t sat_word(logic signed [ACC_W-1:0] v);
		sat_t r;
		logic [ACC_W-WORD_BITS:0] top;
		top = v[ACC_W-1:WORD_BITS-1];
		if (top == '0 || top == '1) begin
			r.w   = v[WORD_BITS-1:0];
			r.ovf = 1'b0;
		end else begin
			r.ovf = 1'b1;
			r.w   = v[ACC_W-1] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
		end
		return r;
	endfunction

	// term table of o = b (x) a, four terms per output component
	function automatic hp_t hp_sel(logic [3:0] k);
		hp_t r;
		unique case (k)
			4'd0:  r = {2'd3, 2'd0, 1'b0};
			4'd1:  r = {2'd0, 2'd3, 1'b0};
			4'd2:  r = {2'd1, 2'd2, 1'b0};
			4'd3:  r = {2'd2, 2'd1, 1'b1};
			4'd4:  r = {2'd3, 2'd1, 1'b0};
			4'd5:  r = {2'd1, 2'd3, 1'b0};
			4'd6:  r = {2'd2, 2'd0, 1'b0};
			4'd7:  r = {2'd0, 2'd2, 1'b1};
			4'd8:  r = {2'd3, 2'd2, 1'b0};
			4'd9:  r = {2'd2, 2'd3, 1'b0};
			4'd10: r = {2'd0, 2'd1, 1'b0};
			4'd11: r = {2'd1, 2'd0, 1'b1};
			4'd12: r = {2'd3, 2'd3, 1'b0};
			4'd13: r = {2'd0, 2'd0, 1'b1};
			4'd14: r = {2'd1, 2'd1, 1'b1};
			4'd15: r = {2'd2, 2'd2, 1'b1};
		endcase
		return r;
	endfunction

endpackage

>>> sv/qau_in_if.sv
// request channel of the quaternion arithmetic unit
interface qau_in_if;
	import qau_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [CMD_W-1:0]            cmd;
	logic signed [WORD_BITS-1:0] a_x;
	logic signed [WORD_BITS-1:0] a_y;
	logic signed [WORD_BITS-1:0] a_z;
	logic signed [WORD_BITS-1:0] a_w;
	logic signed [WORD_BITS-1:0] b_x;
	logic signed [WORD_BITS-1:0] b_y;
	logic signed [WORD_BITS-1:0] b_z;
	logic signed [WORD_BITS-1:0] b_w;
	logic signed [WORD_BITS-1:0] scalar_in;

	modport source (
		output valid, cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
		input  ready
	);
	modport sink (
		input  valid, cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
		output ready
	);
endinterface

>>> sv/qau_out_if.sv
// result channel of the quaternion arithmetic unit
interface qau_out_if;
	import qau_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] r_x;
	logic signed [WORD_BITS-1:0] r_y;
	logic signed [WORD_BITS-1:0] r_z;
	logic signed [WORD_BITS-1:0] r_w;
	logic signed [WORD_BITS-1:0] scalar_out;
	logic [STATUS_W-1:0]         status;

	modport source (
		output valid, r_x, r_y, r_z, r_w, scalar_out, status,
		input  ready
	);
	modport sink (
		input  valid, r_x, r_y, r_z, r_w, scalar_out, status,
		output ready
	);
endinterface

>>> sv/qau_front.sv
// front end: takes requests, classifies the command and pushes them into the queue
module qau_front (
	qau_in_if.sink           in_ch,
	input  qau_pkg::q_stat_t q_stat,
	output logic             push,
	output qau_pkg::item_t   push_data
);
	import qau_pkg::*;

	op_t op;

	// command decode, unknown codes give a zero result
	always_comb begin
		unique case (in_ch.cmd)
			CMD_ADD:   op = OP_ADD;
			CMD_SUB:   op = OP_SUB;
			CMD_MUL:   op = OP_MUL;
			CMD_SCALE: op = OP_SCALE;
			CMD_DIVS:  op = OP_DIVS;
			CMD_CONJ:  op = OP_CONJ;
			CMD_NEG:   op = OP_NEG;
			CMD_DOT:   op = OP_DOT;
			CMD_SQLEN: op = OP_SQLEN;
			CMD_LEN:   op = OP_LEN;
			CMD_NORM:  op = OP_NORM;
			CMD_INV:   op = OP_INV;
			CMD_QUOT:  op = OP_QUOT;
			CMD_LERP:  op = OP_LERP;
			default:   op = OP_NONE;
		endcase
	end

	// accept whenever the queue has room
	assign in_ch.ready = !q_stat.full;
	assign push        = in_ch.valid && !q_stat.full;

	assign push_data.op     = op;
	assign push_data.s_zero = (in_ch.scalar_in == '0);
	assign push_data.a      = {in_ch.a_w, in_ch.a_z, in_ch.a_y, in_ch.a_x};
	assign push_data.b      = {in_ch.b_w, in_ch.b_z, in_ch.b_y, in_ch.b_x};
	assign push_data.s      = in_ch.scalar_in;
endmodule

>>> sv/qau_queue.sv
// short request queue between front end and back end
module qau_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  qau_pkg::item_t   push_data,
	input  logic             pop,
	output qau_pkg::item_t   pop_data,
	output qau_pkg::q_stat_t q_stat
);
	import qau_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign pop_data     = mem_q[rptr_q];
	assign q_stat.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
endmodule

>>> sv/qau_back.sv
// back end: sequencer with shared multiplier, square root and divider, plus result register
module qau_back (
	input  logic             clk,
	input  logic             arst_n,
	input  qau_pkg::q_stat_t q_stat,
	input  qau_pkg::item_t   q_data,
	output logic             q_pop,
	qau_out_if.source        out_ch
);
	import qau_pkg::*;

	localparam int ACC_N   = 5;
	localparam int SC_IDX  = 4;
	localparam int CNT_W   = 5;
	localparam int DCNT_W  = $clog2(NUM_W);
	localparam logic signed [PROD_W-1:0] HALF =
		$signed({{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1));
	localparam logic signed [WORD_BITS:0] ONE =
		$signed({{WORD_BITS{1'b0}}, 1'b1} << FRAC_BITS);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_SQRT, S_DIV, S_DIVIT, S_DIVRND, S_SAT, S_FIN
	} state_t;

	typedef enum logic [2:0] {MM_SCALE, MM_HPROD, MM_DOT, MM_SQ, MM_LERP} mm_t;

	function automatic logic signed [ACC_W-1:0] ext33(logic signed [WORD_BITS:0] v);
		return $signed({{(ACC_W-WORD_BITS-1){v[WORD_BITS]}}, v});
	endfunction

	state_t                   state_q;
	mm_t                      mode_q;
	op_t                      op_q;
	quat_t                    qa_q;
	quat_t                    qb_q;
	word_t                    s_q;
	logic signed [WORD_BITS:0] u_q;
	logic                     ovf_q;
	logic                     dz_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [ACC_W-1:0]  acc_q [ACC_N];

	logic signed [PROD_W-1:0] p_s1;
	logic [2:0]               dst_s1;
	logic                     neg_s1;
	logic                     pv_s1;

	logic [RAD_W-1:0]         sn_q;
	logic [RAD_W-1:0]         sr_q;
	logic [RAD_W-1:0]         sb_q;

	logic [NUM_W-1:0]         dn_q;
	logic [DEN_W-1:0]         dr_q;
	logic [DEN_W-1:0]         dd_q;
	logic                     dvneg_q;
	logic                     dneg_q;
	logic [1:0]               didx_q;
	logic [DCNT_W-1:0]        dcnt_q;

	logic                     out_valid_q;
	quat_t                    r_q;
	word_t                    so_q;
	logic [STATUS_W-1:0]      st_q;

	// multiplier operand selection
	logic signed [WORD_BITS:0] ma;
	logic signed [WORD_BITS:0] mb;
	logic [2:0]                mdst;
	logic                      mneg;
	logic [CNT_W-1:0]          n_steps;
	logic                      mul_issue;
	logic                      mul_done;
	hp_t                       hs;
	quat_t                     sq_src;
	logic [1:0]                k2;

	assign k2     = cnt_q[1:0];
	assign sq_src = (op_q == OP_QUOT) ? qb_q : qa_q;

	always_comb begin
		hs      = hp_sel(cnt_q[3:0]);
		ma      = '0;
		mb      = '0;
		mdst    = '0;
		mneg    = 1'b0;
		n_steps = CNT_W'(4);
		unique case (mode_q)
			MM_SCALE: begin
				ma   = sx_word(qa_q[k2]);
				mb   = sx_word(s_q);
				mdst = {1'b0, k2};
			end
			MM_HPROD: begin
				ma      = sx_word(qb_q[hs.bi]);
				mb      = sx_word(qa_q[hs.ai]);
				mdst    = {1'b0, cnt_q[3:2]};
				mneg    = hs.neg;
				n_steps = CNT_W'(16);
			end
			MM_DOT: begin
				ma   = sx_word(qa_q[k2]);
				mb   = sx_word(qb_q[k2]);
				mdst = 3'(SC_IDX);
			end
			MM_SQ: begin
				ma   = sx_word(sq_src[k2]);
				mb   = sx_word(sq_src[k2]);
				mdst = 3'(SC_IDX);
			end
			MM_LERP: begin
				if (!cnt_q[2]) begin
					ma = sx_word(qa_q[k2]);
					mb = u_q;
				end else begin
					ma = sx_word(qb_q[k2]);
					mb = sx_word(s_q);
				end
				mdst    = {1'b0, k2};
				n_steps = CNT_W'(8);
			end
			default: begin
				ma = '0;
			end
		endcase
	end

	assign mul_issue = (state_q == S_MUL) && (cnt_q < n_steps);
	assign mul_done  = (state_q == S_MUL) && !mul_issue && !pv_s1;

	// multiplier stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= mul_issue;
		end
	end

	always_ff @(posedge clk) begin
		p_s1   <= ma * mb;
		dst_s1 <= mdst;
		neg_s1 <= mneg;
	end

	// rounding of the registered product
	logic signed [PROD_W-1:0] p_rnd;
	logic signed [ACC_W-1:0]  p_ext;

	assign p_rnd = (p_s1 + HALF) >>> FRAC_BITS;
	assign p_ext = $signed({{(ACC_W-RND_W){p_rnd[RND_W-1]}}, p_rnd[RND_W-1:0]});

	// square root step
	logic [RAD_W-1:0] sq_t;
	logic             sq_ge;
	logic [RAD_W-1:0] sr_nx;
	logic [RAD_W-1:0] sn_nx;
	logic signed [ACC_W-1:0] sq_res;

	assign sq_t   = sr_q + sb_q;
	assign sq_ge  = (sn_q >= sq_t);
	assign sr_nx  = sq_ge ? ((sr_q >> 1) + sb_q) : (sr_q >> 1);
	assign sn_nx  = sq_ge ? (sn_q - sq_t) : sn_q;
	assign sq_res = $signed(ACC_W'(sr_nx[RAD_W/2:0]));

	// divisor source at each entry point
	logic signed [ACC_W-1:0] dv_src;
	logic signed [ACC_W-1:0] dv_mag;

	always_comb begin
		unique case (state_q)
			S_IDLE:  dv_src = ext33(sx_word(q_data.s));
			S_SQRT:  dv_src = sq_res;
			default: dv_src = acc_q[SC_IDX];
		endcase
		dv_mag = dv_src[ACC_W-1] ? -dv_src : dv_src;
	end

	// accumulator start values, direct results for add, sub, conj and neg
	logic signed [ACC_W-1:0] acc_init [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			unique case (q_data.op)
				OP_ADD:  acc_init[i] = ext33(sx_word(q_data.a[i])) +
					ext33(sx_word(q_data.b[i]));
				OP_SUB:  acc_init[i] = ext33(sx_word(q_data.a[i])) -
					ext33(sx_word(q_data.b[i]));
				OP_CONJ: acc_init[i] = (i < 3) ? -ext33(sx_word(q_data.a[i])) :
					ext33(sx_word(q_data.a[i]));
				OP_NEG:  acc_init[i] = -ext33(sx_word(q_data.a[i]));
				default: acc_init[i] = '0;
			endcase
		end
	end

	// numerator setup for one component
	word_t                     nw;
	logic signed [WORD_BITS:0] nc;
	logic [WORD_BITS:0]        nmag;

	always_comb begin
		nw = (op_q == OP_QUOT) ? qb_q[didx_q] : qa_q[didx_q];
		nc = sx_word(nw);
		if ((op_q == OP_INV || op_q == OP_QUOT) && didx_q != 2'd3) nc = -nc;
		nmag = nc[WORD_BITS] ? $unsigned(-nc) : $unsigned(nc);
	end

	// restoring divider step
	logic [DEN_W:0]   d_rs;
	logic             d_ge;
	logic [DEN_W:0]   d_diff;
	logic [DEN_W-1:0] dr_nx;

	assign d_rs   = {dr_q, dn_q[NUM_W-1]};
	assign d_ge   = (d_rs >= {1'b0, dd_q});
	assign d_diff = d_rs - {1'b0, dd_q};
	assign dr_nx  = d_ge ? d_diff[DEN_W-1:0] : d_rs[DEN_W-1:0];

	// quotient rounding, ties away from zero
	logic                    d_up;
	logic [ACC_W-1:0]        d_qm;
	logic signed [ACC_W-1:0] d_qs;

	assign d_up = ({dr_q, 1'b0} >= {1'b0, dd_q});
	assign d_qm = {1'b0, dn_q} + ACC_W'(d_up);
	assign d_qs = dneg_q ? -$signed(d_qm) : $signed(d_qm);

	// word clipping of the accumulators
	sat_t sat_r [4];
	sat_t sat_s;
	logic sat_any;
	logic quat_op;

	always_comb begin
		for (int i = 0; i < 4; i++) sat_r[i] = sat_word(acc_q[i]);
		sat_s   = sat_word(acc_q[SC_IDX]);
		sat_any = sat_r[0].ovf | sat_r[1].ovf | sat_r[2].ovf | sat_r[3].ovf;
		quat_op = !(op_q == OP_DOT || op_q == OP_SQLEN || op_q == OP_LEN || op_q == OP_NONE);
	end

	assign q_pop = (state_q == S_IDLE) && !q_stat.empty;

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready && state_q != S_FIN) out_valid_q <= 1'b0;
			if (pv_s1) begin
				acc_q[dst_s1] <= neg_s1 ? (acc_q[dst_s1] - p_ext) : (acc_q[dst_s1] + p_ext);
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_stat.empty) begin
						op_q  <= q_data.op;
						qa_q  <= q_data.a;
						qb_q  <= q_data.b;
						s_q   <= q_data.s;
						u_q   <= ONE - sx_word(q_data.s);
						ovf_q <= 1'b0;
						dz_q  <= 1'b0;
						cnt_q <= '0;
						for (int i = 0; i < 4; i++) acc_q[i] <= acc_init[i];
						acc_q[SC_IDX] <= '0;
						unique case (q_data.op)
							OP_ADD, OP_SUB, OP_CONJ, OP_NEG: begin
								state_q <= S_FIN;
							end
							OP_SCALE: begin
								mode_q  <= MM_SCALE;
								state_q <= S_MUL;
							end
							OP_MUL: begin
								mode_q  <= MM_HPROD;
								state_q <= S_MUL;
							end
							OP_DOT: begin
								mode_q  <= MM_DOT;
								state_q <= S_MUL;
							end
							OP_SQLEN, OP_LEN, OP_NORM, OP_INV, OP_QUOT: begin
								mode_q  <= MM_SQ;
								state_q <= S_MUL;
							end
							OP_LERP: begin
								mode_q  <= MM_LERP;
								state_q <= S_MUL;
							end
							OP_DIVS: begin
								if (q_data.s_zero) begin
									dz_q    <= 1'b1;
									state_q <= S_FIN;
								end else begin
									dd_q    <= dv_mag[DEN_W-1:0];
									dvneg_q <= dv_src[ACC_W-1];
									didx_q  <= '0;
									state_q <= S_DIV;
								end
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_MUL: begin
					if (mul_issue) cnt_q <= cnt_q + 1'b1;
					if (mul_done) begin
						unique case (mode_q)
							MM_LERP: state_q <= S_SAT;
							MM_SQ: begin
								priority if (op_q == OP_INV || op_q == OP_QUOT) begin
									if (acc_q[SC_IDX] == '0) begin
										dz_q    <= 1'b1;
										state_q <= S_FIN;
									end else begin
										dd_q    <= dv_mag[DEN_W-1:0];
										dvneg_q <= dv_src[ACC_W-1];
										didx_q  <= '0;
										state_q <= S_DIV;
									end
								end else if (op_q == OP_SQLEN) begin
									state_q <= S_FIN;
								end else begin
									sn_q    <= {acc_q[SC_IDX][RAD_W-FRAC_BITS-1:0],
										{FRAC_BITS{1'b0}}};
									sr_q    <= '0;
									sb_q    <= {2'b01, {(RAD_W-2){1'b0}}};
									state_q <= S_SQRT;
								end
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_SQRT: begin
					sn_q <= sn_nx;
					sr_q <= sr_nx;
					sb_q <= sb_q >> 2;
					if (sb_q == RAD_W'(1)) begin
						priority if (op_q == OP_LEN) begin
							acc_q[SC_IDX] <= sq_res;
							state_q       <= S_FIN;
						end else if (sq_res == '0) begin
							dz_q    <= 1'b1;
							state_q <= S_FIN;
						end else begin
							dd_q    <= dv_mag[DEN_W-1:0];
							dvneg_q <= dv_src[ACC_W-1];
							didx_q  <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					dn_q    <= {nmag[WORD_BITS-1:0], {FRAC_BITS{1'b0}}};
					dr_q    <= '0;
					dneg_q  <= nc[WORD_BITS] ^ dvneg_q;
					dcnt_q  <= '0;
					state_q <= S_DIVIT;
				end
				S_DIVIT: begin
					dn_q   <= {dn_q[NUM_W-2:0], d_ge};
					dr_q   <= dr_nx;
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_W'(NUM_W - 1)) state_q <= S_DIVRND;
				end
				S_DIVRND: begin
					acc_q[{1'b0, didx_q}] <= d_qs;
					if (didx_q == 2'd3) begin
						state_q <= (op_q == OP_QUOT) ? S_SAT : S_FIN;
					end else begin
						didx_q  <= didx_q + 1'b1;
						state_q <= S_DIV;
					end
				end
				S_SAT: begin
					ovf_q <= ovf_q | sat_any;
					cnt_q <= '0;
					for (int i = 0; i < ACC_N; i++) acc_q[i] <= '0;
					if (op_q == OP_LERP) begin
						for (int i = 0; i < 4; i++) qa_q[i] <= sat_r[i].w;
						mode_q <= MM_SQ;
					end else begin
						for (int i = 0; i < 4; i++) qb_q[i] <= sat_r[i].w;
						mode_q <= MM_HPROD;
					end
					state_q <= S_MUL;
				end
				S_FIN: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						priority if (dz_q) begin
							r_q  <= '0;
							so_q <= '0;
							st_q <= ST_DZ;
						end else if (quat_op) begin
							for (int i = 0; i < 4; i++) r_q[i] <= sat_r[i].w;
							so_q <= '0;
							st_q <= (ovf_q | sat_any) ? ST_SAT : ST_OK;
						end else begin
							r_q  <= '0;
							so_q <= sat_s.w;
							st_q <= (ovf_q | sat_s.ovf) ? ST_SAT : ST_OK;
						end
						state_q <= S_IDLE;
					end else begin
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.r_x        = r_q[0];
	assign out_ch.r_y        = r_q[1];
	assign out_ch.r_z        = r_q[2];
	assign out_ch.r_w        = r_q[3];
	assign out_ch.scalar_out = so_q;
	assign out_ch.status     = st_q;
endmodule

>>> sv/quaternion_arithmetic_unit.sv
// top level of the quaternion arithmetic unit
//
// Quaternion ALU in signed Q3.28. A front end takes one request per cycle, while the queue
// has room, into a four-entry queue while the back end works; the back end runs one
// request at a time on a shared 33x33 multiplier (one product per cycle, registered), a
// one-bit-per-cycle square root and a one-bit-per-cycle restoring divider. The result
// register holds a finished result while the next request is already being worked on.
module quaternion_arithmetic_unit (
	input  logic      clk,
	input  logic      arst_n,
	qau_in_if.sink    in_ch,
	qau_out_if.source out_ch
);
	import qau_pkg::*;

	`include "quaternion_arithmetic_unit_assert.svh"

	q_stat_t q_stat;
	logic    q_push;
	logic    q_pop;
	item_t   q_push_data;
	item_t   q_pop_data;

	qau_front u_front (
		.in_ch     (in_ch),
		.q_stat    (q_stat),
		.push      (q_push),
		.push_data (q_push_data)
	);

	qau_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.q_stat    (q_stat)
	);

	qau_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.q_data (q_pop_data),
		.q_pop  (q_pop),
		.out_ch (out_ch)
	);

	// queue never overruns or underruns, divide-by-zero results carry zero fields
	`QAU_ASSERT_NOW(a_no_ready_full, q_stat.full, !in_ch.ready, "request taken while queue full")
	`QAU_ASSERT_NOW(a_no_pop_empty, q_pop, !q_stat.empty, "queue popped while empty")
	`QAU_ASSERT_NOW(a_dz_zero, out_ch.valid && out_ch.status == ST_DZ, out_ch.r_x == '0 && out_ch.r_y == '0 && out_ch.r_z == '0 && out_ch.r_w == '0 && out_ch.scalar_out == '0, "zero divisor result not cleared")
	`QAU_ASSERT_NEXT(a_pop_busy, q_pop, !q_pop, "back end took two requests in a row")
endmodule
